// ===== rtl/core/swk_pkg.sv =====
// Shared constants, tables and sideband types for the swerve wheel kinematics block.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps
package swk_pkg;

  localparam int WHEELS       = 4;
  localparam int WIDX_W       = $clog2(WHEELS);
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_ITERS = 30;

  localparam int ROT_W = 34;  // rotation datapath
  localparam int ZR_W  = 34;  // rotation residual angle
  localparam int DX_W  = 33;  // rotated drive vector
  localparam int SUM_W = 34;  // wheel vector
  localparam int VEC_W = 36;  // vectoring datapath
  localparam int MAG_W = 33;  // wheel magnitude
  localparam int PCT_W = 17;  // drive and turn shares, Q16

  localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

  localparam logic [31:0] ANG_HALF = 32'(1) << (31 - ANGLE_BITS);
  localparam logic [31:0] ANG_MASK = ~((32'(1) << (32 - ANGLE_BITS)) - 32'(1));

  localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef struct packed {
    logic [PCT_W-1:0]  turn_pct;
    logic [PCT_W-1:0]  drive_pct;
    logic signed [15:0] turn;
    logic [WIDX_W-1:0] wheel;
  } rot_tag_t;

  typedef struct packed {
    logic [WIDX_W-1:0] wheel;
    logic              zero;
  } vec_tag_t;

endpackage

// ===== rtl/core/swk_rotate.sv =====
// Pipelined rotation CORDIC, one iteration per stage, followed by a gain stage.
// Depends on swk_pkg.
`timescale 1ns / 1ps
module swk_rotate (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic signed [swk_pkg::ROT_W-1:0] x_i,
  input  logic signed [swk_pkg::ROT_W-1:0] y_i,
  input  logic signed [swk_pkg::ZR_W-1:0]  z_i,
  input  logic                        skip_i,
  input  swk_pkg::rot_tag_t           tag_i,
  output logic                        vld_o,
  output logic signed [swk_pkg::DX_W-1:0]  x_o,
  output logic signed [swk_pkg::DX_W-1:0]  y_o,
  output swk_pkg::rot_tag_t           tag_o
);
  import swk_pkg::*;

  localparam int PRD_W = ROT_W + 31;

  logic signed [ROT_W-1:0] x_q [CORDIC_ITERS];
  logic signed [ROT_W-1:0] y_q [CORDIC_ITERS];
  logic signed [ZR_W-1:0]  z_q [CORDIC_ITERS];
  logic                    skip_q [CORDIC_ITERS];
  rot_tag_t                tag_q [CORDIC_ITERS];
  logic                    vld_q [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_stage
    logic signed [ROT_W-1:0] xi, yi, xn, yn;
    logic signed [ZR_W-1:0]  zi, zn;
    logic                    ski, vi;
    rot_tag_t                tgi;

    if (i == 0) begin : g_first
      assign xi  = x_i;
      assign yi  = y_i;
      assign zi  = z_i;
      assign ski = skip_i;
      assign tgi = tag_i;
      assign vi  = vld_i;
    end else begin : g_next
      assign xi  = x_q[i-1];
      assign yi  = y_q[i-1];
      assign zi  = z_q[i-1];
      assign ski = skip_q[i-1];
      assign tgi = tag_q[i-1];
      assign vi  = vld_q[i-1];
    end

    always_comb begin
      xn = xi;
      yn = yi;
      zn = zi;
      if (!ski) begin
        if (!zi[ZR_W-1]) begin
          xn = xi - (yi >>> i);
          yn = yi + (xi >>> i);
          zn = zi - $signed(ZR_W'(ATAN_TAB[i]));
        end else begin
          xn = xi + (yi >>> i);
          yn = yi - (xi >>> i);
          zn = zi + $signed(ZR_W'(ATAN_TAB[i]));
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= xn;
        y_q[i]    <= yn;
        z_q[i]    <= zn;
        skip_q[i] <= ski;
        tag_q[i]  <= tgi;
      end
    end
  end

  // remove CORDIC gain
  logic signed [PRD_W-1:0] px, py, rx, ry;
  logic signed [DX_W-1:0]  x_d, y_d;
  logic signed [DX_W-1:0]  x_q2, y_q2;
  rot_tag_t                tag_q2;
  logic                    vld_q2;

  assign px = PRD_W'(x_q[CORDIC_ITERS-1]) * PRD_W'(GAIN_Q30);
  assign py = PRD_W'(y_q[CORDIC_ITERS-1]) * PRD_W'(GAIN_Q30);
  assign rx = (px + (PRD_W'(1) <<< 29)) >>> 30;
  assign ry = (py + (PRD_W'(1) <<< 29)) >>> 30;

  always_comb begin
    if (skip_q[CORDIC_ITERS-1]) begin
      x_d = DX_W'(x_q[CORDIC_ITERS-1]);
      y_d = DX_W'(y_q[CORDIC_ITERS-1]);
    end else begin
      x_d = DX_W'(rx);
      y_d = DX_W'(ry);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q2 <= 1'b0;
    end else if (en_i) begin
      vld_q2 <= vld_q[CORDIC_ITERS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q2   <= x_d;
      y_q2   <= y_d;
      tag_q2 <= tag_q[CORDIC_ITERS-1];
    end
  end

  assign vld_o = vld_q2;
  assign x_o   = x_q2;
  assign y_o   = y_q2;
  assign tag_o = tag_q2;

endmodule

// ===== rtl/core/swk_vector.sv =====
// Pipelined vectoring CORDIC giving bearing and magnitude, followed by a gain stage.
// Depends on swk_pkg.
`timescale 1ns / 1ps
module swk_vector (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic signed [swk_pkg::VEC_W-1:0] x_i,
  input  logic signed [swk_pkg::VEC_W-1:0] y_i,
  input  logic [31:0]                 z_i,
  input  logic                        skip_i,
  input  swk_pkg::vec_tag_t           tag_i,
  output logic                        vld_o,
  output logic [swk_pkg::MAG_W-1:0]   mag_o,
  output logic [31:0]                 ang_o,
  output swk_pkg::vec_tag_t           tag_o
);
  import swk_pkg::*;

  localparam int PRD_W = VEC_W + 31;

  logic signed [VEC_W-1:0] x_q [CORDIC_ITERS];
  logic signed [VEC_W-1:0] y_q [CORDIC_ITERS];
  logic [31:0]             z_q [CORDIC_ITERS];
  logic                    skip_q [CORDIC_ITERS];
  vec_tag_t                tag_q [CORDIC_ITERS];
  logic                    vld_q [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_stage
    logic signed [VEC_W-1:0] xi, yi, xn, yn;
    logic [31:0]             zi, zn;
    logic                    ski, vi;
    vec_tag_t                tgi;

    if (i == 0) begin : g_first
      assign xi  = x_i;
      assign yi  = y_i;
      assign zi  = z_i;
      assign ski = skip_i;
      assign tgi = tag_i;
      assign vi  = vld_i;
    end else begin : g_next
      assign xi  = x_q[i-1];
      assign yi  = y_q[i-1];
      assign zi  = z_q[i-1];
      assign ski = skip_q[i-1];
      assign tgi = tag_q[i-1];
      assign vi  = vld_q[i-1];
    end

    always_comb begin
      xn = xi;
      yn = yi;
      zn = zi;
      if (!ski) begin
        if (!yi[VEC_W-1]) begin
          xn = xi + (yi >>> i);
          yn = yi - (xi >>> i);
          zn = zi + ATAN_TAB[i];
        end else begin
          xn = xi - (yi >>> i);
          yn = yi + (xi >>> i);
          zn = zi - ATAN_TAB[i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= xn;
        y_q[i]    <= yn;
        z_q[i]    <= zn;
        skip_q[i] <= ski;
        tag_q[i]  <= tgi;
      end
    end
  end

  logic signed [PRD_W-1:0] px, rx;
  logic [MAG_W-1:0]        mag_d, mag_q2;
  logic [31:0]             ang_q2;
  vec_tag_t                tag_q2;
  logic                    vld_q2;

  assign px = PRD_W'(x_q[CORDIC_ITERS-1]) * PRD_W'(GAIN_Q30);
  assign rx = (px + (PRD_W'(1) <<< 29)) >>> 30;

  always_comb begin
    if (skip_q[CORDIC_ITERS-1]) begin
      mag_d = MAG_W'(x_q[CORDIC_ITERS-1]);
    end else begin
      mag_d = MAG_W'(rx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q2 <= 1'b0;
    end else if (en_i) begin
      vld_q2 <= vld_q[CORDIC_ITERS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q2 <= mag_d;
      ang_q2 <= z_q[CORDIC_ITERS-1];
      tag_q2 <= tag_q[CORDIC_ITERS-1];
    end
  end

  assign vld_o = vld_q2;
  assign mag_o = mag_q2;
  assign ang_o = ang_q2;
  assign tag_o = tag_q2;

endmodule

// ===== rtl/core/swerve_wheel_kinematics_top.sv =====
// Four-wheel swerve inverse kinematics: command sequencer, wheel mixing, register port.
// Depends on swk_pkg, swk_rotate and swk_vector.
//
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   drive_x, drive_y, turn_rate, heading
// out      out  out_valid_o / out_ready_i wheel_index, wheel_angle, angle_valid,
//                                         wheel_speed, last_wheel
// cfg      in   psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//
// Each command issues one wheel job per cycle into a 65-stage pipeline (31 rotation,
// 2 mixing, 31 vectoring, 1 output), one result per cycle, while the output is not stalled;
// a new command is taken as the last wheel job of the previous one issues.
// Reset clears all valid bits and restores register defaults.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
module swerve_wheel_kinematics_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [15:0]         drive_x_i,
  input  logic signed [15:0]         drive_y_i,
  input  logic signed [15:0]         turn_rate_i,
  input  logic [15:0]                heading_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [swk_pkg::WIDX_W-1:0] wheel_index_o,
  output logic [15:0]                wheel_angle_o,
  output logic                       angle_valid_o,
  output logic [15:0]                wheel_speed_o,
  output logic                       last_wheel_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import swk_pkg::*;

  localparam logic [1:0] REG_MAX_SPEED  = 2'd0;
  localparam logic [1:0] REG_TURN_SHARE = 2'd1;
  localparam logic [1:0] REG_AUTO_MODE  = 2'd2;

  localparam int PDX_W = DX_W + 18;
  localparam int PT_W  = 34;
  localparam int SXS_W = PDX_W;
  localparam int SP_W  = MAG_W + 17;

  // configuration
  logic [15:0] max_speed_q, turn_share_q;
  logic        auto_mode_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q  <= 16'd32768;
      turn_share_q <= 16'd26214;
      auto_mode_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MAX_SPEED:  max_speed_q  <= pwdata[15:0];
        REG_TURN_SHARE: turn_share_q <= pwdata[15:0];
        REG_AUTO_MODE:  auto_mode_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_SPEED:  prdata = {16'd0, max_speed_q};
      REG_TURN_SHARE: prdata = {16'd0, turn_share_q};
      REG_AUTO_MODE:  prdata = {31'd0, auto_mode_q};
      default:        prdata = 32'd0;
    endcase
  end

  // pipeline advance
  logic out_vld_q, en;
  assign en = !out_vld_q || out_ready_i;

  // command hold and wheel sequencer
  logic              hold_vld_q;
  logic [WIDX_W-1:0] cnt_q;
  logic signed [15:0] hx_q, hy_q, ht_q;
  logic [15:0]       hh_q;
  logic              in_acc, last_job;

  assign last_job   = cnt_q == WIDX_W'(WHEELS - 1);
  assign in_ready_o = en && (!hold_vld_q || last_job);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else if (in_acc) begin
      hold_vld_q <= 1'b1;
      cnt_q      <= '0;
    end else if (en && hold_vld_q) begin
      cnt_q <= cnt_q + WIDX_W'(1);
      if (last_job) begin
        hold_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hx_q <= drive_x_i;
      hy_q <= drive_y_i;
      ht_q <= turn_rate_i;
      hh_q <= heading_i;
    end
  end

  // heading quadrant, residual angle, shares
  logic [1:0]              quad;
  logic [15:0]             ru;
  logic signed [ROT_W-1:0] ax, ay, qx, qy;
  logic signed [ZR_W-1:0]  rz;
  logic signed [16:0]      t17;
  logic [16:0]             tabs;
  logic [32:0]             tsum;
  logic [PCT_W-1:0]        turn_pct, drive_pct;
  rot_tag_t                rtag;

  assign quad = 2'((hh_q + 16'h2000) >> 14);
  assign ru   = hh_q - {quad, 14'd0};
  assign rz   = ZR_W'($signed({ru, 16'd0}));
  assign ax   = ROT_W'(hx_q) <<< 15;
  assign ay   = ROT_W'(hy_q) <<< 15;

  always_comb begin
    unique case (quad)
      2'd0: begin qx = ax;  qy = ay;  end
      2'd1: begin qx = -ay; qy = ax;  end
      2'd2: begin qx = -ax; qy = -ay; end
      default: begin qx = ay; qy = -ax; end
    endcase
  end

  assign t17  = 17'(ht_q);
  assign tabs = t17[16] ? 17'(-t17) : 17'(t17);
  assign tsum = 33'(turn_share_q) * 33'(tabs) + 33'd16384;

  always_comb begin
    if (auto_mode_q) begin
      turn_pct  = PCT_W'(32768);
      drive_pct = PCT_W'(32768);
    end else begin
      turn_pct  = tsum[31:15];
      drive_pct = PCT_W'(65536) - tsum[31:15];
    end
  end

  assign rtag = '{turn_pct: turn_pct, drive_pct: drive_pct, turn: ht_q, wheel: cnt_q};

  logic                    rot_vld;
  logic signed [DX_W-1:0]  rot_x, rot_y;
  rot_tag_t                rot_tag;

  swk_rotate u_rotate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (hold_vld_q),
    .x_i    (qx),
    .y_i    (qy),
    .z_i    (rz),
    .skip_i (ru == 16'd0),
    .tag_i  (rtag),
    .vld_o  (rot_vld),
    .x_o    (rot_x),
    .y_o    (rot_y),
    .tag_o  (rot_tag)
  );

  // weighted products
  logic                    m_vld_q;
  logic signed [PDX_W-1:0] pdx_q, pdy_q;
  logic signed [PT_W-1:0]  pt_q;
  logic [WIDX_W-1:0]       m_wheel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= rot_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pdx_q     <= PDX_W'($signed({1'b0, rot_tag.drive_pct})) * PDX_W'(rot_x);
      pdy_q     <= PDX_W'($signed({1'b0, rot_tag.drive_pct})) * PDX_W'(rot_y);
      pt_q      <= PT_W'($signed({1'b0, rot_tag.turn_pct})) * PT_W'(rot_tag.turn);
      m_wheel_q <= rot_tag.wheel;
    end
  end

  // wheel vector sum, turn vector steps clockwise per wheel
  logic signed [SXS_W-1:0] tterm, sxs, sys;
  logic                    sx_neg, sy_neg;
  logic                    s_vld_q;
  logic signed [SUM_W-1:0] sx_q, sy_q;
  logic [WIDX_W-1:0]       s_wheel_q;

  assign tterm  = SXS_W'(pt_q) <<< 15;
  assign sx_neg = m_wheel_q[1];
  assign sy_neg = m_wheel_q[1] ^ m_wheel_q[0];
  assign sxs    = pdx_q + (sx_neg ? -tterm : tterm) + SXS_W'(32768);
  assign sys    = pdy_q + (sy_neg ? -tterm : tterm) + SXS_W'(32768);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else if (en) begin
      s_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q      <= SUM_W'(sxs >>> 16);
      sy_q      <= SUM_W'(sys >>> 16);
      s_wheel_q <= m_wheel_q;
    end
  end

  // bearing from forward: Y is forward, X is sideways
  logic                    vneg;
  logic signed [VEC_W-1:0] vx, vy;
  vec_tag_t                vtag;

  assign vneg = sy_q[SUM_W-1];
  assign vx   = vneg ? -VEC_W'(sy_q) : VEC_W'(sy_q);
  assign vy   = vneg ? -VEC_W'(sx_q) : VEC_W'(sx_q);
  assign vtag = '{wheel: s_wheel_q, zero: (sx_q == '0) && (sy_q == '0)};

  logic             vec_vld;
  logic [MAG_W-1:0] vec_mag;
  logic [31:0]      vec_ang;
  vec_tag_t         vec_tag;

  swk_vector u_vector (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_vld_q),
    .x_i    (vx),
    .y_i    (vy),
    .z_i    (vneg ? 32'h8000_0000 : 32'h0),
    .skip_i (vy == '0),
    .tag_i  (vtag),
    .vld_o  (vec_vld),
    .mag_o  (vec_mag),
    .ang_o  (vec_ang),
    .tag_o  (vec_tag)
  );

  // speed scale, angle rounding, output register
  logic [SP_W-1:0]  sp, spr;
  logic [31:0]      ang_r;
  logic [15:0]      speed_d;
  logic [WIDX_W-1:0] wheel_q;
  logic [15:0]      angle_q, speed_q;
  logic             avalid_q, last_q;

  assign sp    = SP_W'(vec_mag) * SP_W'(max_speed_q) + SP_W'(32'h2000_0000);
  assign spr   = sp >> 30;
  assign ang_r = (vec_ang + ANG_HALF) & ANG_MASK;

  always_comb begin
    if (|spr[SP_W-1:16]) begin
      speed_d = 16'hFFFF;
    end else begin
      speed_d = spr[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vec_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wheel_q  <= vec_tag.wheel;
      last_q   <= vec_tag.wheel == WIDX_W'(WHEELS - 1);
      avalid_q <= !vec_tag.zero;
      angle_q  <= vec_tag.zero ? 16'd0 : ang_r[31:16];
      speed_q  <= vec_tag.zero ? 16'd0 : speed_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign wheel_index_o = wheel_q;
  assign wheel_angle_o = angle_q;
  assign angle_valid_o = avalid_q;
  assign wheel_speed_o = speed_q;
  assign last_wheel_o  = last_q;

  a_last_on_final_wheel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_wheel_o == (wheel_index_o == WIDX_W'(WHEELS - 1))))
    else $error("last_wheel does not match wheel index");

  a_zero_vector_outputs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !angle_valid_o) |-> (wheel_speed_o == 16'd0 && wheel_angle_o == 16'd0))
    else $error("zero wheel vector with nonzero angle or speed");

  a_accept_starts_wheels : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (hold_vld_q && cnt_q == '0))
    else $error("accepted command did not start at first wheel");

endmodule
